### design/rbb_pkg.sv
// shared types and constants for the rgb box blur
package rbb_pkg;

  localparam int MAX_KERNEL_DEF = 15;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 13;
  localparam int KREG_W = 4;
  localparam int WREG_W = 11;
  localparam int HREG_W = 13;

  localparam logic [CFG_IW-1:0] REG_KERNEL = 2'd0;
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd2;

  localparam logic [KREG_W-1:0] KERNEL_RST = 4'd3;
  localparam logic [WREG_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [HREG_W-1:0] HEIGHT_RST = 13'd1024;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int WORD_W      = 32;

  typedef struct packed {
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_done;
  } out_item_t;

  typedef struct packed {
    logic frame_done;
  } job_t;

endpackage

### design/rgb_box_blur_top.sv
// top level of the rgb box blur: configuration, front, queue, line store, back
// Streaming K x K box blur of RGBA pixels in raster order. Items (pixels or
// drain ticks) go into a front stage that writes the line store and queues
// one job per output; up to four jobs wait while the back computes. For each
// output the back reads the centre pixel, scans the R*C window pixels that
// fall inside the frame (R rows, C columns, at most K*K reads through the
// single line store read port), flushes, runs the bit-per-cycle divider for
// S steps, where S is the width of the window sum (16 at the default sizes),
// and then loads the output register before it takes the next job. An input
// is held off for one cycle after reset and after each configuration write,
// and from the frame's last job until its output transfer completes. The
// line store needs no clearing after reset.
module rgb_box_blur_top import rbb_pkg::*; #(
  parameter int MAX_KERNEL = MAX_KERNEL_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam int DEPTH = MAX_KERNEL * (MAX_WIDTH + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_KERNEL + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int KKW   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int NW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DW    = $clog2(DEPTH);

  logic [KREG_W-1:0] kreg_r;
  logic [WREG_W-1:0] wreg_r;
  logic [HREG_W-1:0] hreg_r;
  logic              pend_r;
  logic              restart;
  logic [KW-1:0]     k_c;
  logic [WW-1:0]     w_c;
  logic [HW-1:0]     h_c;
  logic [KW-1:0]     half_c;
  logic [KW-1:0]     ahead_c;
  logic [KW-1:0]     k_r;
  logic [WW-1:0]     w_r;
  logic [HW-1:0]     h_r;
  logic [NW-1:0]     n_r;
  logic [DW-1:0]     delay_r;
  logic [AW-1:0]     hw_r;
  logic [KKW-1:0]    kk_r;

  logic              q_push;
  job_t              q_push_job;
  logic              q_pop;
  job_t              q_pop_job;
  logic              q_full;
  logic              q_empty;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              end_pend;
  logic              end_clear;

  assign restart = cfg_we && (cfg_index == REG_KERNEL || cfg_index == REG_WIDTH ||
                              cfg_index == REG_HEIGHT);
  assign end_clear = out_valid && !out_stall && out_data.frame_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kreg_r <= KERNEL_RST;
      wreg_r <= WIDTH_RST;
      hreg_r <= HEIGHT_RST;
      pend_r <= 1'b1;
    end else begin
      pend_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          REG_KERNEL: kreg_r <= cfg_data[KREG_W-1:0];
          REG_WIDTH:  wreg_r <= cfg_data[WREG_W-1:0];
          REG_HEIGHT: hreg_r <= cfg_data[HREG_W-1:0];
          default:    kreg_r <= kreg_r;
        endcase
      end
    end
  end

  always_comb begin
    if (kreg_r == '0) begin
      k_c = KW'(1);
    end else if (32'(kreg_r) > MAX_KERNEL) begin
      k_c = KW'(MAX_KERNEL);
    end else begin
      k_c = KW'(kreg_r);
    end
    if (wreg_r == '0) begin
      w_c = WW'(1);
    end else if (32'(wreg_r) > MAX_WIDTH) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(wreg_r);
    end
    if (hreg_r == '0) begin
      h_c = HW'(1);
    end else if (32'(hreg_r) > MAX_HEIGHT) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(hreg_r);
    end
    half_c  = k_c >> 1;
    ahead_c = k_c - 1'b1 - half_c;
  end

  always_ff @(posedge clk) begin
    k_r     <= k_c;
    w_r     <= w_c;
    h_r     <= h_c;
    n_r     <= NW'(32'(w_c) * 32'(h_c));
    delay_r <= DW'(32'(ahead_c) * 32'(w_c) + 32'(ahead_c));
    hw_r    <= AW'(32'(half_c) * 32'(w_c));
    kk_r    <= KKW'(32'(k_c) * 32'(k_c));
  end

  rbb_front #(
    .MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .DEPTH(DEPTH), .AW(AW), .NW(NW), .DW(DW)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .restart(restart), .hold(pend_r),
    .n_i(n_r), .delay_i(delay_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_full(q_full), .q_push(q_push), .q_job(q_push_job),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .end_clear(end_clear), .end_pend(end_pend)
  );

  rbb_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_job(q_push_job),
    .pop(q_pop), .pop_job(q_pop_job),
    .full(q_full), .empty(q_empty)
  );

  rbb_line_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  rbb_back #(
    .MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .DEPTH(DEPTH), .AW(AW), .KW(KW), .WW(WW), .HW(HW), .KKW(KKW)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .restart(restart),
    .k_i(k_r), .w_i(w_r), .h_i(h_r), .hw_i(hw_r), .kk_i(kk_r),
    .q_empty(q_empty), .q_job(q_pop_job), .q_pop(q_pop),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue overflow");

  a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.frame_done) |-> end_pend)
    else $error("frame end output without pending frame end");

  a_end_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (end_clear && !restart) |=> !end_pend)
    else $error("frame end not released after transfer");

  a_no_accept_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    end_pend |-> in_stall)
    else $error("item taken while frame end pending");

endmodule

### design/rbb_line_store.sv
// ring of rgba words, one write port and one registered read port
module rbb_line_store import rbb_pkg::*; #(
  parameter int DEPTH = MAX_KERNEL_DEF * (MAX_WIDTH_DEF + 1),
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/rbb_queue.sv
// short job queue between front and back
module rbb_queue import rbb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  job_t           slot_r [QUEUE_DEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;

  assign full    = (cnt_r == (QAW+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### design/rbb_front.sv
// front: accepts items, stores pixels, decides which items release an output
module rbb_front import rbb_pkg::*; #(
  parameter int MAX_KERNEL = MAX_KERNEL_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int DEPTH      = MAX_KERNEL * (MAX_WIDTH + 1),
  parameter int AW         = $clog2(DEPTH),
  parameter int NW         = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  parameter int DW         = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic              hold,
  input  logic [NW-1:0]     n_i,
  input  logic [DW-1:0]     delay_i,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  input  logic              q_full,
  output logic              q_push,
  output job_t              q_job,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [WORD_W-1:0] wr_data,
  input  logic              end_clear,
  output logic              end_pend
);

  localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + DEPTH + 2);
  localparam int EW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic [PW-1:0] pos_r;
  logic [EW-1:0] em_r;
  logic [AW-1:0] wa_r;
  logic          endp_r;
  logic          acc;
  logic [PW-1:0] pos_inc;
  logic          emit;
  logic          last;

  assign in_stall = hold | q_full | endp_r;
  assign acc      = in_valid & ~in_stall;
  assign pos_inc  = pos_r + 1'b1;
  assign emit     = (pos_inc > (PW'(delay_i) + PW'(em_r))) && (NW'(em_r) < n_i);
  assign last     = (NW'(em_r) == n_i - 1'b1);
  assign q_push   = acc & emit;
  assign q_job.frame_done = last;
  assign wr_en    = acc && (PW'(n_i) > pos_r);
  assign wr_addr  = wa_r;
  assign wr_data  = (in_data.operation == OP_PIXEL) ?
                    {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in} : '0;
  assign end_pend = endp_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      pos_r  <= '0;
      em_r   <= '0;
      wa_r   <= '0;
      endp_r <= 1'b0;
    end else begin
      if (end_clear) begin
        endp_r <= 1'b0;
      end
      if (acc) begin
        pos_r <= pos_inc;
        if (wr_en) begin
          wa_r <= (wa_r == AW'(DEPTH - 1)) ? '0 : wa_r + 1'b1;
        end
        if (emit) begin
          if (last) begin
            pos_r  <= '0;
            em_r   <= '0;
            wa_r   <= '0;
            endp_r <= 1'b1;
          end else begin
            em_r <= em_r + 1'b1;
          end
        end
      end
    end
  end

endmodule

### design/rbb_back.sv
// back: window sum over the line store, divide by k*k, output register
module rbb_back import rbb_pkg::*; #(
  parameter int MAX_KERNEL = MAX_KERNEL_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int DEPTH      = MAX_KERNEL * (MAX_WIDTH + 1),
  parameter int AW         = $clog2(DEPTH),
  parameter int KW         = $clog2(MAX_KERNEL + 1),
  parameter int WW         = $clog2(MAX_WIDTH + 1),
  parameter int HW         = $clog2(MAX_HEIGHT + 1),
  parameter int KKW        = $clog2(MAX_KERNEL * MAX_KERNEL + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic [KW-1:0]     k_i,
  input  logic [WW-1:0]     w_i,
  input  logic [HW-1:0]     h_i,
  input  logic [AW-1:0]     hw_i,
  input  logic [KKW-1:0]    kk_i,
  input  logic              q_empty,
  input  job_t              q_job,
  output logic              q_pop,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [WORD_W-1:0] rd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam int SW  = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int DCW = $clog2(SW + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]     st_r;
  logic [HW-1:0]  ci_r;
  logic [WW-1:0]  cj_r;
  logic [AW-1:0]  qrow_r;
  logic [HW-1:0]  r_r;
  logic [HW-1:0]  re_r;
  logic [WW-1:0]  c_r;
  logic [WW-1:0]  cs_r;
  logic [WW-1:0]  ce_r;
  logic [AW-1:0]  row_r;
  logic           fd_r;
  logic           cenv_r;
  logic           pixv_r;
  logic [7:0]     alpha_r;
  logic [SW-1:0]  sum_r [3];
  logic [KKW-1:0] rem_r [3];
  logic [DCW-1:0] dcnt_r;
  logic           out_valid_r;
  out_item_t      out_data_r;

  logic [KW-1:0]  half;
  logic [KW-1:0]  ahead;
  logic           ci_ge;
  logic           cj_ge;
  logic [31:0]    re_t;
  logic [31:0]    ce_t;
  logic [HW-1:0]  rs;
  logic [HW-1:0]  re;
  logic [WW-1:0]  cs;
  logic [WW-1:0]  ce;
  logic [AW-1:0]  row0;
  logic [AW:0]    cen_s;
  logic [AW:0]    scan_s;
  logic [AW:0]    next_row_s;
  logic [AW-1:0]  next_row;
  logic [SW-1:0]  sum_n [3];
  logic [KKW-1:0] rem_n [3];
  logic [KKW:0]   trial [3];
  logic           out_free;

  always_comb begin
    half   = k_i >> 1;
    ahead  = k_i - 1'b1 - half;
    ci_ge  = 32'(ci_r) >= 32'(half);
    cj_ge  = 32'(cj_r) >= 32'(half);
    rs     = ci_ge ? HW'(32'(ci_r) - 32'(half)) : '0;
    cs     = cj_ge ? WW'(32'(cj_r) - 32'(half)) : '0;
    re_t   = 32'(ci_r) + 32'(ahead);
    ce_t   = 32'(cj_r) + 32'(ahead);
    re     = (re_t >= 32'(h_i)) ? h_i - 1'b1 : HW'(re_t);
    ce     = (ce_t >= 32'(w_i)) ? w_i - 1'b1 : WW'(ce_t);
    if (!ci_ge) begin
      row0 = '0;
    end else if (qrow_r >= hw_i) begin
      row0 = qrow_r - hw_i;
    end else begin
      row0 = AW'({1'b0, qrow_r} + (AW+1)'(DEPTH) - {1'b0, hw_i});
    end
    cen_s      = {1'b0, qrow_r} + (AW+1)'(cj_r);
    scan_s     = {1'b0, row_r} + (AW+1)'(c_r);
    next_row_s = {1'b0, row_r} + (AW+1)'(w_i);
    next_row   = (next_row_s >= (AW+1)'(DEPTH)) ? AW'(next_row_s - (AW+1)'(DEPTH))
                                                : AW'(next_row_s);
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_r[i], sum_r[i][SW-1]};
      if (trial[i] >= {1'b0, kk_i}) begin
        rem_n[i] = KKW'(trial[i] - {1'b0, kk_i});
        sum_n[i] = {sum_r[i][SW-2:0], 1'b1};
      end else begin
        rem_n[i] = KKW'(trial[i]);
        sum_n[i] = {sum_r[i][SW-2:0], 1'b0};
      end
    end
  end

  assign q_pop    = (st_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (q_pop) begin
      rd_en   = 1'b1;
      rd_addr = (cen_s >= (AW+1)'(DEPTH)) ? AW'(cen_s - (AW+1)'(DEPTH)) : AW'(cen_s);
    end else if (st_r == S_SCAN) begin
      rd_en   = 1'b1;
      rd_addr = (scan_s >= (AW+1)'(DEPTH)) ? AW'(scan_s - (AW+1)'(DEPTH)) : AW'(scan_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      st_r        <= S_IDLE;
      ci_r        <= '0;
      cj_r        <= '0;
      qrow_r      <= '0;
      cenv_r      <= 1'b0;
      pixv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cenv_r <= q_pop;
      pixv_r <= (st_r == S_SCAN);
      if (cenv_r) begin
        alpha_r <= rd_data[31:24];
      end
      if (pixv_r) begin
        sum_r[0] <= sum_r[0] + SW'(rd_data[7:0]);
        sum_r[1] <= sum_r[1] + SW'(rd_data[15:8]);
        sum_r[2] <= sum_r[2] + SW'(rd_data[23:16]);
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            fd_r  <= q_job.frame_done;
            r_r   <= rs;
            re_r  <= re;
            c_r   <= cs;
            cs_r  <= cs;
            ce_r  <= ce;
            row_r <= row0;
            for (int i = 0; i < 3; i++) begin
              sum_r[i] <= '0;
            end
            st_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (c_r == ce_r) begin
            c_r   <= cs_r;
            row_r <= next_row;
            r_r   <= r_r + 1'b1;
            if (r_r == re_r) begin
              st_r <= S_FLUSH;
            end
          end else begin
            c_r <= c_r + 1'b1;
          end
        end
        S_FLUSH: begin
          dcnt_r <= '0;
          for (int i = 0; i < 3; i++) begin
            rem_r[i] <= '0;
          end
          st_r <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= sum_n[i];
            rem_r[i] <= rem_n[i];
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCW'(SW - 1)) begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r.red_out    <= sum_r[0][7:0];
            out_data_r.green_out  <= sum_r[1][7:0];
            out_data_r.blue_out   <= sum_r[2][7:0];
            out_data_r.alpha_out  <= alpha_r;
            out_data_r.frame_done <= fd_r;
            out_valid_r <= 1'b1;
            if (fd_r) begin
              ci_r   <= '0;
              cj_r   <= '0;
              qrow_r <= '0;
            end else if (cj_r == w_i - 1'b1) begin
              cj_r   <= '0;
              ci_r   <= ci_r + 1'b1;
              qrow_r <= (({1'b0, qrow_r} + (AW+1)'(w_i)) >= (AW+1)'(DEPTH)) ?
                        AW'({1'b0, qrow_r} + (AW+1)'(w_i) - (AW+1)'(DEPTH)) :
                        AW'({1'b0, qrow_r} + (AW+1)'(w_i));
            end else begin
              cj_r <= cj_r + 1'b1;
            end
            st_r <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
